// ===== src/pvp_pkg.sv =====
`timescale 1ns / 1ps

package pvp_pkg;

  // Field and word types
  typedef logic signed [15:0] coord_t;   // Q8.8 point coordinate
  typedef logic signed [15:0] coef_t;    // Q4.12 matrix entry
  typedef logic signed [15:0] quot_t;    // Q4.12 saturated quotient
  typedef logic        [63:0] row_t;     // four packed entries
  typedef logic signed [31:0] prod_t;    // entry * coordinate
  typedef logic signed [33:0] clip_t;    // Q14.20 clip value, never saturated
  typedef logic        [32:0] mag_t;     // |clip|
  typedef logic        [44:0] num_t;     // |clip| << 12
  typedef logic        [2:0]  cfg_idx_t;

  localparam int unsigned ROWS      = 4;
  localparam int unsigned COEFS     = 4;
  localparam int unsigned Q_BITS    = 16;
  localparam int unsigned DIV_SHIFT = 12;

  // Config register indexes
  localparam cfg_idx_t REG_ROW_X = 3'd0;
  localparam cfg_idx_t REG_ROW_Y = 3'd1;
  localparam cfg_idx_t REG_ROW_Z = 3'd2;
  localparam cfg_idx_t REG_ROW_W = 3'd3;

  // Row order inside the matrix array
  localparam int unsigned ROW_X = 0;
  localparam int unsigned ROW_Y = 1;
  localparam int unsigned ROW_Z = 2;
  localparam int unsigned ROW_W = 3;

  // Identity matrix after reset
  localparam row_t RST_ROW_X = 64'h0000_0000_0000_1000;
  localparam row_t RST_ROW_Y = 64'h0000_0000_1000_0000;
  localparam row_t RST_ROW_Z = 64'h0000_1000_0000_0000;
  localparam row_t RST_ROW_W = 64'h1000_0000_0000_0000;

  // Pipeline depth: products, sums, magnitudes, then the divider lane
  // (overflow check, one stage per quotient bit, saturation).
  localparam int unsigned FRONT_STAGES = 3;
  localparam int unsigned LANE_STAGES  = Q_BITS + 2;
  localparam int unsigned PIPE_STAGES  = FRONT_STAGES + LANE_STAGES;

  typedef struct packed {
    quot_t screen_x;
    quot_t screen_y;
    quot_t depth;
    logic  w_is_zero;
  } result_t;

  function automatic coef_t row_coef(input row_t row, input int unsigned k);
    return row[16*k +: 16];
  endfunction

endpackage

// ===== src/perspective_vertex_project_unit.sv =====
`timescale 1ns / 1ps

// Perspective vertex projection: (x, y, z, 1) times a 4x4 Q4.12 matrix, then
// clip x, y, z divided by clip w, each given as a saturated Q4.12 value.
//
// Channels: input beats (in_point_x/y/z, Q8.8) on in_valid / in_stall, result
// beats (out_screen_x, out_screen_y, out_depth, out_w_is_zero) on out_valid /
// out_stall. A beat moves when valid is high and stall is low.
// Config: cfg_index 0..3 selects row x, y, z, w; cfg_data holds four Q4.12
// entries, entry 0 in the low bits. cfg_ready is always high; other indexes
// are ignored. The user must rewrite rows only while the pipe is empty; the
// block itself does not enforce this.
//
// Throughput: one vertex per cycle while in_stall is low. A beat passes through
// products, sums, magnitudes, an 18-stage divider lane with one restoring step
// per quotient bit, then the output register. When clip w is exactly zero, all
// three results are 0 and out_w_is_zero is 1.
// Reset clears every valid bit and loads the identity matrix.
// Receiver stall: a one-entry skid register catches the beat that reaches the
// output while it is held; once the skid is full, in_stall rises and the
// whole pipe freezes until the output drains. Nothing is lost or repeated.
module perspective_vertex_project_unit (
  input  logic              clk,
  input  logic              rst_n,

  input  logic              in_valid,
  output logic              in_stall,
  input  pvp_pkg::coord_t   in_point_x,
  input  pvp_pkg::coord_t   in_point_y,
  input  pvp_pkg::coord_t   in_point_z,

  output logic              out_valid,
  input  logic              out_stall,
  output pvp_pkg::quot_t    out_screen_x,
  output pvp_pkg::quot_t    out_screen_y,
  output pvp_pkg::quot_t    out_depth,
  output logic              out_w_is_zero,

  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  pvp_pkg::cfg_idx_t cfg_index,
  input  pvp_pkg::row_t     cfg_data
);
  import pvp_pkg::*;

  // ---------------------------------------------------------------- config
  row_t mat_r [0:ROWS-1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_r[ROW_X] <= RST_ROW_X;
      mat_r[ROW_Y] <= RST_ROW_Y;
      mat_r[ROW_Z] <= RST_ROW_Z;
      mat_r[ROW_W] <= RST_ROW_W;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROW_X: mat_r[ROW_X] <= cfg_data;
        REG_ROW_Y: mat_r[ROW_Y] <= cfg_data;
        REG_ROW_Z: mat_r[ROW_Z] <= cfg_data;
        REG_ROW_W: mat_r[ROW_W] <= cfg_data;
        default:   ;
      endcase
    end
  end

  // ---------------------------------------------------------------- control
  logic en;                        // whole pipe advances
  logic skid_valid_r;
  logic v_r  [0:PIPE_STAGES-1];    // valid per stage
  logic wz_r [0:LANE_STAGES];      // w == 0, aligned from the magnitude stage

  assign en       = !skid_valid_r;
  assign in_stall = skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PIPE_STAGES; i++) begin
        v_r[i] <= 1'b0;
      end
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int i = 1; i < PIPE_STAGES; i++) begin
        v_r[i] <= v_r[i-1];
      end
    end
  end

  // ---------------------------------------------------------------- stage 1
  // 16x16 products; constant term is entry 3 times 1.0 in Q8.8
  prod_t prod_r [0:ROWS-1][0:COEFS-1];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < ROWS; r++) begin
        prod_r[r][0] <= row_coef(mat_r[r], 0) * in_point_x;
        prod_r[r][1] <= row_coef(mat_r[r], 1) * in_point_y;
        prod_r[r][2] <= row_coef(mat_r[r], 2) * in_point_z;
        prod_r[r][3] <= prod_t'(signed'({row_coef(mat_r[r], 3), 8'b0}));
      end
    end
  end

  // ---------------------------------------------------------------- stage 2
  clip_t clip_r [0:ROWS-1];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < ROWS; r++) begin
        clip_r[r] <= clip_t'(prod_r[r][0]) + clip_t'(prod_r[r][1])
                   + clip_t'(prod_r[r][2]) + clip_t'(prod_r[r][3]);
      end
    end
  end

  // ---------------------------------------------------------------- stage 3
  // Magnitudes and quotient signs for the three lanes
  num_t num_r [0:ROWS-2];
  logic neg_r [0:ROWS-2];
  mag_t den_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < ROWS - 1; r++) begin
        num_r[r] <= {mag_t'(clip_r[r][33] ? -clip_r[r] : clip_r[r]), 12'b0};
        neg_r[r] <= clip_r[r][33] ^ clip_r[ROW_W][33];
      end
      den_r <= mag_t'(clip_r[ROW_W][33] ? -clip_r[ROW_W] : clip_r[ROW_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wz_r[0] <= (clip_r[ROW_W] == '0);
      for (int j = 1; j <= LANE_STAGES; j++) begin
        wz_r[j] <= wz_r[j-1];
      end
    end
  end

  // ---------------------------------------------------------------- divide
  quot_t quot [0:ROWS-2];

  for (genvar r = 0; r < ROWS - 1; r++) begin : g_lane
    pvp_div_lane u_lane (
      .clk     (clk),
      .en      (en),
      .num_mag (num_r[r]),
      .den_mag (den_r),
      .neg     (neg_r[r]),
      .quot    (quot[r])
    );
  end

  // ---------------------------------------------------------------- output
  result_t res_nxt;
  result_t out_r;
  result_t skid_r;
  logic    out_valid_r;
  logic    arrive;

  assign arrive = en && v_r[PIPE_STAGES-1];

  always_comb begin
    if (wz_r[LANE_STAGES]) begin
      res_nxt = '{screen_x: '0, screen_y: '0, depth: '0, w_is_zero: 1'b1};
    end else begin
      res_nxt = '{screen_x: quot[ROW_X], screen_y: quot[ROW_Y],
                  depth: quot[ROW_Z], w_is_zero: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (!out_stall) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (arrive) begin
      if (out_valid_r && out_stall) begin
        skid_r       <= res_nxt;
        skid_valid_r <= 1'b1;
      end else begin
        out_r       <= res_nxt;
        out_valid_r <= 1'b1;
      end
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_screen_x  = out_r.screen_x;
  assign out_screen_y  = out_r.screen_y;
  assign out_depth     = out_r.depth;
  assign out_w_is_zero = out_r.w_is_zero;

  // ---------------------------------------------------------------- checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a beat while output is empty");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |=> $stable(v_r[PIPE_STAGES-1]))
    else $error("pipe moved while frozen");

  a_catch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall && !skid_valid_r && v_r[PIPE_STAGES-1] |=> skid_valid_r)
    else $error("arriving beat not caught by skid");

  a_zero_w: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_w_is_zero |->
      out_screen_x == '0 && out_screen_y == '0 && out_depth == '0)
    else $error("zero w result not cleared");

endmodule

// ===== src/pvp_div_lane.sv =====
`timescale 1ns / 1ps

// Pipelined saturating divide: sign applied to |num| / |den|, restoring,
// one quotient bit per stage.
module pvp_div_lane (
  input  logic          clk,
  input  logic          en,
  input  pvp_pkg::num_t num_mag,
  input  pvp_pkg::mag_t den_mag,
  input  logic          neg,
  output pvp_pkg::quot_t quot
);
  import pvp_pkg::*;

  num_t              r_r   [0:Q_BITS-1];
  mag_t              d_r   [0:Q_BITS-1];
  logic [Q_BITS-1:0] q_r   [0:Q_BITS];
  logic              neg_r [0:Q_BITS];
  logic              ovf_r [0:Q_BITS];
  quot_t             quot_r;

  // Quotient of 2^16 or more saturates either way
  logic ovf_nxt;
  assign ovf_nxt = {4'b0, num_mag} >= {den_mag, 16'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0]   <= num_mag;
      d_r[0]   <= den_mag;
      q_r[0]   <= '0;
      neg_r[0] <= neg;
      ovf_r[0] <= ovf_nxt;
    end
  end

  for (genvar i = 1; i <= Q_BITS; i++) begin : g_step
    localparam int unsigned K = Q_BITS - i;
    logic [48:0] sub_den;
    logic [48:0] rem_ext;
    logic [48:0] diff;
    logic        ge;

    assign sub_den = {16'b0, d_r[i-1]} << K;
    assign rem_ext = {4'b0, r_r[i-1]};
    assign ge      = rem_ext >= sub_den;
    assign diff    = rem_ext - sub_den;

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[i]   <= q_r[i-1] | (Q_BITS'(ge) << K);
        neg_r[i] <= neg_r[i-1];
        ovf_r[i] <= ovf_r[i-1];
      end
    end

    if (i < Q_BITS) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          r_r[i] <= ge ? diff[44:0] : r_r[i-1];
          d_r[i] <= d_r[i-1];
        end
      end
    end
  end

  // Saturate to [-32768, 32767] and apply sign
  logic [Q_BITS-1:0] q_fin;
  logic              pos_sat;
  logic              neg_sat;
  quot_t             quot_nxt;

  assign q_fin   = q_r[Q_BITS];
  assign pos_sat = ovf_r[Q_BITS] || q_fin[Q_BITS-1];
  assign neg_sat = ovf_r[Q_BITS] || (q_fin > 16'h8000);

  always_comb begin
    if (neg_r[Q_BITS]) begin
      quot_nxt = neg_sat ? 16'sh8000 : quot_t'(~q_fin + 16'd1);
    end else begin
      quot_nxt = pos_sat ? 16'sh7FFF : quot_t'(q_fin);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quot_r <= quot_nxt;
    end
  end

  assign quot = quot_r;

endmodule
